[rtl/icb_pkg.sv]
package icb_pkg;

  localparam int LINE_WIDTH = 640;
  localparam int COL_W      = $clog2(LINE_WIDTH);
  localparam int ROW_W      = 13;
  localparam int PIX_W      = 24;
  localparam int CHAN_W     = 8;
  localparam int SUM_W      = 11;

  localparam logic [ROW_W-1:0] ROWS_RESET = ROW_W'(480);
  localparam logic [ROW_W-1:0] ROWS_MIN   = ROW_W'(3);
  localparam logic [ROW_W-1:0] ROWS_MAX   = ROW_W'(4096);

  // ceil(2^16 / 5); error stays below 1/5 for n <= 1275
  localparam int RECIP_5    = 13108;
  localparam int RECIP_SH   = 16;
  localparam int RECIP_W    = 14;

  typedef enum logic [1:0] {
    K_STORE,
    K_PASS,
    K_AVG,
    K_DRAIN
  } kind_t;

  // floor(n / 5) for n <= 1275
  function automatic logic [CHAN_W-1:0] div5(input logic [SUM_W-1:0] n);
    logic [SUM_W+RECIP_W-1:0] prod;
    prod = (SUM_W+RECIP_W)'(n) * (SUM_W+RECIP_W)'(RECIP_5);
    return prod[RECIP_SH +: CHAN_W];
  endfunction

endpackage

[rtl/inplace_cross_blur_unit.sv]
// channel  dir  handshake                  payload
// in_      in   in_tvalid / in_tready      tdata: red, green, blue; tuser: flush
// out_     out  out_tvalid / out_tready    tdata: red, green, blue; tlast: frame_last
// cfg_     in   cfg_we                     cfg_wdata: frame_rows
//
// One word per cycle sustained; a pixel is held in stage one (line ram
// read), then is averaged and written back as it moves into the output register.
// Each word reads raw_line at the next column; the current column comes from
// the previous word's read, so each ram sees one read and one write per cycle.
// Reset and any cfg write restart the frame. Out stalls hold stage one and the
// input; discarded words are taken whenever in_tready is high and leave no trace.
module inplace_cross_blur_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [icb_pkg::PIX_W-1:0]   in_tdata,   // red, green, blue
  input  logic                        in_tuser,   // flush
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [icb_pkg::PIX_W-1:0]   out_tdata,  // red, green, blue
  output logic                        out_tlast,  // frame_last
  input  logic                        cfg_we,
  input  logic [icb_pkg::ROW_W-1:0]   cfg_wdata   // frame_rows
);

  import icb_pkg::*;

  localparam logic [COL_W-1:0] COL_LAST = COL_W'(LINE_WIDTH - 1);

  logic [ROW_W-1:0] rows_r, rows_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [COL_W-1:0] col_r, col_nxt;

  logic             s1_valid_r, s1_valid_nxt;
  kind_t            s1_kind_r;
  logic             s1_last_r;
  logic [PIX_W-1:0] s1_pix_r;
  logic [COL_W-1:0] s1_addr_r;

  logic [PIX_W-1:0] hold_r;
  logic [PIX_W-1:0] prev_done_r;

  logic             out_valid_r;
  logic [PIX_W-1:0] out_data_r;
  logic             out_last_r;

  logic             take, keep, pix_phase, col_wrap;
  kind_t            kind;
  logic [COL_W-1:0] rd_addr;
  logic             s1_emit, s1_adv, out_free, s1_wr_raw, s1_wr_done;
  logic [PIX_W-1:0] raw_rd, done_rd, avg, res;
  logic [ROW_W-1:0] cfg_rows;

  // stage 0: classify and advance position
  always_comb begin
    pix_phase = row_r < rows_r;
    col_wrap  = col_r == COL_LAST;
    keep      = pix_phase ? !in_tuser : in_tuser;
    take      = in_tvalid && in_tready;
    rd_addr   = col_wrap ? '0 : col_r + COL_W'(1);
    if (!pix_phase) begin
      kind = K_DRAIN;
    end else if (row_r == '0) begin
      kind = K_STORE;
    end else if (row_r == ROW_W'(1)) begin
      kind = K_PASS;
    end else begin
      kind = K_AVG;
    end

    if (cfg_wdata < ROWS_MIN) begin
      cfg_rows = ROWS_MIN;
    end else if (cfg_wdata > ROWS_MAX) begin
      cfg_rows = ROWS_MAX;
    end else begin
      cfg_rows = cfg_wdata;
    end

    rows_nxt = rows_r;
    row_nxt  = row_r;
    col_nxt  = col_r;
    if (cfg_we) begin
      rows_nxt = cfg_rows;
      row_nxt  = '0;
      col_nxt  = '0;
    end else if (take && keep) begin
      col_nxt = rd_addr;
      if (col_wrap) begin
        row_nxt = pix_phase ? row_r + ROW_W'(1) : '0;
      end
    end
  end

  // stage 1 control
  always_comb begin
    s1_emit    = s1_kind_r != K_STORE;
    out_free   = !out_valid_r || out_tready;
    s1_adv     = s1_valid_r && (!s1_emit || out_free);
    in_tready  = !s1_valid_r || s1_adv;
    s1_wr_raw  = s1_adv && (s1_kind_r != K_DRAIN);
    s1_wr_done = s1_adv && (s1_kind_r == K_PASS || s1_kind_r == K_AVG);
    if (take && keep) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
  end

  // own = hold, above = done_rd, left = prev_done, right = raw_rd, below = pix
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      avg[k*CHAN_W +: CHAN_W] = div5(
        SUM_W'(hold_r[k*CHAN_W +: CHAN_W]) +
        SUM_W'(done_rd[k*CHAN_W +: CHAN_W]) +
        SUM_W'(prev_done_r[k*CHAN_W +: CHAN_W]) +
        SUM_W'(raw_rd[k*CHAN_W +: CHAN_W]) +
        SUM_W'(s1_pix_r[k*CHAN_W +: CHAN_W]));
    end
    res = (s1_kind_r == K_AVG) ? avg : hold_r;
  end

  icb_line_ram #(.DEPTH(LINE_WIDTH), .WIDTH(PIX_W)) u_raw_line (
    .clk   (clk),
    .we    (s1_wr_raw),
    .waddr (s1_addr_r),
    .wdata (s1_pix_r),
    .re    (take && keep),
    .raddr (rd_addr),
    .rdata (raw_rd)
  );

  icb_line_ram #(.DEPTH(LINE_WIDTH), .WIDTH(PIX_W)) u_done_line (
    .clk   (clk),
    .we    (s1_wr_done),
    .waddr (s1_addr_r),
    .wdata (res),
    .re    (take && keep),
    .raddr (col_r),
    .rdata (done_rd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r      <= ROWS_RESET;
      row_r       <= '0;
      col_r       <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      prev_done_r <= '0;
    end else begin
      rows_r     <= rows_nxt;
      row_r      <= row_nxt;
      col_r      <= col_nxt;
      s1_valid_r <= s1_valid_nxt;
      if (s1_adv && s1_emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        prev_done_r <= '0;
      end else if (s1_wr_done) begin
        prev_done_r <= res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && keep) begin
      s1_kind_r <= kind;
      s1_last_r <= !pix_phase && col_wrap;
      s1_pix_r  <= in_tdata;
      s1_addr_r <= col_r;
    end
    if (s1_adv) begin
      hold_r <= raw_rd;
    end
    if (s1_adv && s1_emit) begin
      out_data_r <= res;
      out_last_r <= s1_last_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

[rtl/icb_line_ram.sv]
module icb_line_ram #(
  parameter int DEPTH  = 640,
  parameter int WIDTH  = 24,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
